/* hw/rtl/fdp_pkg.sv */
// ----------------------------------------------------------------------------
// fdp_pkg
// Types and constants shared by the format-directed number printer: the
// input and result words, the command word passed from front to back, and
// the character codes.
// ----------------------------------------------------------------------------
package fdp_pkg;

	localparam int ARG_W   = 64;
	localparam int COUNT_W = 31;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LC_X    = 8'h78;
	localparam logic [7:0] CH_UC_X    = 8'h58;
	localparam logic [7:0] CH_LC_A    = 8'h61;
	localparam logic [7:0] CH_UC_A    = 8'h41;
	localparam logic [7:0] CH_LC_C    = 8'h63;
	localparam logic [7:0] CH_LC_D    = 8'h64;
	localparam logic [7:0] CH_LC_I    = 8'h69;
	localparam logic [7:0] CH_LC_U    = 8'h75;
	localparam logic [7:0] CH_LC_P    = 8'h70;

	// reciprocal of ten for 32-bit dividends, quotient is (n * RECIP10) >> 35
	localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int          RECIP10_SH  = 35;

	typedef struct packed {
		logic               start_of_format;
		logic [7:0]         fmt_char;
		logic [ARG_W-1:0]   arg_value;
	} item_t;

	typedef struct packed {
		logic [7:0]         out_char;
		logic               last_of_run;
		logic [COUNT_W-1:0] total_count;
	} result_t;

	typedef enum logic [2:0] {
		K_NONE,
		K_CHAR,
		K_DEC,
		K_HEX,
		K_PTR
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic             clr;
		logic             neg;
		logic             upper;
		logic [ARG_W-1:0] value;
	} cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UC_A : CH_LC_A;
		if (nib < 4'd10)
			hex_char = CH_ZERO + {4'b0, nib};
		else
			hex_char = base + {4'b0, nib} - 8'd10;
	endfunction

endpackage

/* hw/rtl/fdp_front.sv */
// ----------------------------------------------------------------------------
// fdp_front
// Accepts format words, tracks the pending conversion flag and turns each
// word into one command for the back end.
// ----------------------------------------------------------------------------
module fdp_front #(
	parameter int POINTER_BITS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  fdp_pkg::item_t item,
	input  logic           q_full,
	output logic           push,
	output fdp_pkg::cmd_t  cmd
);

	localparam logic [fdp_pkg::ARG_W-1:0] PTR_MASK =
		{fdp_pkg::ARG_W{1'b1}} >> (fdp_pkg::ARG_W - POINTER_BITS);

	logic        pending_q;
	logic        pend;
	logic        pending_nxt;
	logic [31:0] low32;
	logic [31:0] mag;

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;
	assign pend       = item.start_of_format ? 1'b0 : pending_q;
	assign low32      = item.arg_value[31:0];
	assign mag        = low32[31] ? (~low32 + 32'd1) : low32;

	always_comb begin
		cmd         = '0;
		cmd.kind    = fdp_pkg::K_NONE;
		cmd.clr     = item.start_of_format;
		pending_nxt = 1'b0;
		if (pend) begin
			case (item.fmt_char)
				fdp_pkg::CH_LC_C: begin
					cmd.kind  = fdp_pkg::K_CHAR;
					cmd.value = {56'b0, item.arg_value[7:0]};
				end
				fdp_pkg::CH_LC_D, fdp_pkg::CH_LC_I: begin
					cmd.kind  = fdp_pkg::K_DEC;
					cmd.neg   = low32[31];
					cmd.value = {32'b0, mag};
				end
				fdp_pkg::CH_LC_U: begin
					cmd.kind  = fdp_pkg::K_DEC;
					cmd.value = {32'b0, low32};
				end
				fdp_pkg::CH_LC_X: begin
					cmd.kind  = fdp_pkg::K_HEX;
					cmd.value = {32'b0, low32};
				end
				fdp_pkg::CH_UC_X: begin
					cmd.kind  = fdp_pkg::K_HEX;
					cmd.upper = 1'b1;
					cmd.value = {32'b0, low32};
				end
				fdp_pkg::CH_LC_P: begin
					cmd.kind  = fdp_pkg::K_PTR;
					cmd.value = item.arg_value & PTR_MASK;
				end
				fdp_pkg::CH_PERCENT: begin
					cmd.kind  = fdp_pkg::K_CHAR;
					cmd.value = {56'b0, fdp_pkg::CH_PERCENT};
				end
				default: begin
					cmd.kind = fdp_pkg::K_NONE;
				end
			endcase
		end else if (item.fmt_char == fdp_pkg::CH_PERCENT) begin
			pending_nxt = 1'b1;
		end else begin
			cmd.kind  = fdp_pkg::K_CHAR;
			cmd.value = {56'b0, item.fmt_char};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (push) begin
			pending_q <= pending_nxt;
		end
	end

endmodule

/* hw/rtl/fdp_queue.sv */
// ----------------------------------------------------------------------------
// fdp_queue
// Short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module fdp_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fdp_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output fdp_pkg::cmd_t rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	fdp_pkg::cmd_t    entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

/* hw/rtl/fdp_back.sv */
// ----------------------------------------------------------------------------
// fdp_back
// Carries out one command at a time: decimal digit extraction, hex digit
// walk, prefixes, and the saturating character count into the result
// register.
// ----------------------------------------------------------------------------
module fdp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  fdp_pkg::cmd_t    cmd,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output fdp_pkg::result_t result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t                         state_q;
	fdp_pkg::kind_t                 kind_q;
	logic                           upper_q;
	logic [fdp_pkg::ARG_W-1:0]      val_q;
	logic [31:0]                    mag_q;
	logic [3:0]                     idx_q;
	logic [1:0]                     pre_q;
	logic [fdp_pkg::COUNT_W-1:0]    count_q;
	logic                           res_valid_q;
	fdp_pkg::result_t               res_q;

	logic                           emit_ok;
	logic                           emit_fire;
	logic [63:0]                    prod;
	logic [31:0]                    quo;
	logic [31:0]                    quo10;
	logic [3:0]                     rem;
	logic [3:0]                     top;
	logic [3:0]                     nib;
	logic [7:0]                     ch;
	logic                           last;
	logic [fdp_pkg::COUNT_W-1:0]    cnt_nxt;

	assign pop          = (state_q == ST_IDLE) && q_valid;
	assign emit_ok      = !res_valid_q || !result_stall;
	assign emit_fire    = (state_q == ST_EMIT) && emit_ok;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign prod  = 64'(mag_q) * 64'(fdp_pkg::RECIP10);
	assign quo   = 32'(prod >> fdp_pkg::RECIP10_SH);
	assign quo10 = {quo[28:0], 3'b0} + {quo[30:0], 1'b0};
	assign rem   = 4'(mag_q - quo10);

	always_comb begin
		top = '0;
		for (int i = 1; i < 16; i++) begin
			if (cmd.value[4*i +: 4] != 4'h0)
				top = 4'(i);
		end
	end

	assign nib     = val_q[{idx_q, 2'b00} +: 4];
	assign last    = (pre_q == 2'd0) && (idx_q == 4'd0);
	assign cnt_nxt = (count_q == {fdp_pkg::COUNT_W{1'b1}}) ? count_q
	                 : count_q + {{(fdp_pkg::COUNT_W-1){1'b0}}, 1'b1};

	always_comb begin
		if (pre_q != 2'd0) begin
			if (kind_q == fdp_pkg::K_PTR)
				ch = (pre_q == 2'd2) ? fdp_pkg::CH_ZERO : fdp_pkg::CH_LC_X;
			else
				ch = fdp_pkg::CH_MINUS;
		end else if (kind_q == fdp_pkg::K_CHAR) begin
			ch = val_q[7:0];
		end else begin
			ch = fdp_pkg::hex_char(nib, upper_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			count_q     <= '0;
			kind_q      <= fdp_pkg::K_NONE;
			upper_q     <= 1'b0;
			val_q       <= '0;
			mag_q       <= '0;
			idx_q       <= '0;
			pre_q       <= '0;
			res_q       <= '0;
		end else begin
			res_valid_q <= emit_fire || (res_valid_q && result_stall);
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						kind_q  <= cmd.kind;
						upper_q <= cmd.upper;
						val_q   <= cmd.value;
						if (cmd.clr)
							count_q <= '0;
						case (cmd.kind)
							fdp_pkg::K_CHAR: begin
								idx_q   <= '0;
								pre_q   <= 2'd0;
								state_q <= ST_EMIT;
							end
							fdp_pkg::K_HEX: begin
								idx_q   <= top;
								pre_q   <= 2'd0;
								state_q <= ST_EMIT;
							end
							fdp_pkg::K_PTR: begin
								idx_q   <= top;
								pre_q   <= 2'd2;
								state_q <= ST_EMIT;
							end
							fdp_pkg::K_DEC: begin
								idx_q   <= '0;
								mag_q   <= cmd.value[31:0];
								pre_q   <= {1'b0, cmd.neg};
								state_q <= ST_DIV;
							end
							default: begin
								idx_q   <= '0;
								pre_q   <= 2'd0;
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DIV: begin
					val_q[{idx_q, 2'b00} +: 4] <= rem;
					mag_q                       <= quo;
					if (quo == 32'd0)
						state_q <= ST_EMIT;
					else
						idx_q <= idx_q + 4'd1;
				end
				ST_EMIT: begin
					if (emit_ok) begin
						res_q.out_char    <= ch;
						res_q.last_of_run <= last;
						res_q.total_count <= cnt_nxt;
						count_q           <= cnt_nxt;
						if (pre_q != 2'd0)
							pre_q <= pre_q - 2'd1;
						else if (idx_q != 4'd0)
							idx_q <= idx_q - 4'd1;
						else
							state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/format_directed_number_printer_top.sv */
// ----------------------------------------------------------------------------
// format_directed_number_printer_top
// Integer printf-style formatter: echoes format bytes and expands %c %d %i
// %u %x %X %p %% into characters, one result word per character.
// path: a taken word is written into the queue, popped into the back end and
//   sent out through the result register; %d %i %u first run through the
//   divide-by-ten unit, one digit a cycle; the back end serves one command at
//   a time and the 2-entry queue lets the front keep taking words until full
// reset: clears the pending-percent flag, the count, the queue and the result
// ----------------------------------------------------------------------------
module format_directed_number_printer_top #(
	parameter int POINTER_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  fdp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output fdp_pkg::result_t result
);

	logic          push;
	logic          q_full;
	logic          q_valid;
	logic          pop;
	fdp_pkg::cmd_t cmd_in;
	fdp_pkg::cmd_t cmd_out;

	fdp_front #(
		.POINTER_BITS(POINTER_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.cmd        (cmd_in)
	);

	fdp_queue #(
		.DEPTH(2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (cmd_in),
		.full     (q_full),
		.pop      (pop),
		.nonempty (q_valid),
		.rdata    (cmd_out)
	);

	fdp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.cmd          (cmd_out),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.total_count != '0)
		else $error("result word with zero count");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

	a_full_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> q_valid)
		else $error("queue full but empty");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for format_directed_number_printer_top. A queue of
// format bytes feeds a clocked driver; a clocked monitor compares every
// emitted character, its last flag and its running count against a
// prediction built when the input word is taken. Directed bytes cover the
// echo path, every conversion and the corner values of each, followed by
// random format sequences under three sender/receiver pacing mixes.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import fdp_pkg::*;

	localparam int PTR_BITS = 64;
	localparam logic [7:0] CH_LC_S = 8'h73;
	localparam logic [7:0] CH_UC_Z = 8'h5A;
	localparam logic [127:0] HEX_LOWER = "0123456789abcdef";
	localparam logic [127:0] HEX_UPPER = "0123456789ABCDEF";

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	item_t   pending_items[$];
	result_t expected_chars[$];

	logic               percent_armed;
	logic [COUNT_W-1:0] chars_so_far;

	int send_idle_pct;
	int recv_stall_pct;
	int words_taken;
	int chars_checked;
	int errors;

	format_directed_number_printer_top #(
		.POINTER_BITS(PTR_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (errors < 40)
			$display("MISMATCH at %0t: %s", $realtime, what);
		errors++;
	endtask

	// expected characters of one format byte

	function automatic void emit_char(input logic [7:0] ch);
		if (chars_so_far != {COUNT_W{1'b1}})
			chars_so_far = chars_so_far + 1'b1;
		expected_chars.push_back('{out_char: ch, last_of_run: 1'b0, total_count: chars_so_far});
	endfunction

	function automatic void emit_hex(input logic [63:0] v, input logic upper);
		int top;
		logic [3:0] nib;
		top = 0;
		for (int i = 15; i > 0; i--) begin
			if (v[4*i +: 4] != 4'h0) begin
				top = i;
				break;
			end
		end
		for (int i = top; i >= 0; i--) begin
			nib = v[4*i +: 4];
			emit_char(upper ? HEX_UPPER[8*(15-nib) +: 8] : HEX_LOWER[8*(15-nib) +: 8]);
		end
	endfunction

	function automatic void emit_dec(input logic [31:0] mag, input logic neg);
		logic [7:0] digs [10];
		int n;
		n = 0;
		if (neg)
			emit_char(CH_MINUS);
		do begin
			digs[n] = CH_ZERO + 8'(mag % 32'd10);
			mag = mag / 32'd10;
			n++;
		end while (mag != 0);
		while (n > 0) begin
			n--;
			emit_char(digs[n]);
		end
	endfunction

	function automatic void predict_format_byte(input item_t w);
		int first;
		logic [31:0] low32;
		logic [63:0] ptr_mask;
		result_t tail;
		first = expected_chars.size();
		low32 = w.arg_value[31:0];
		ptr_mask = {64{1'b1}} >> (64 - PTR_BITS);
		if (w.start_of_format) begin
			percent_armed = 1'b0;
			chars_so_far = '0;
		end
		if (percent_armed) begin
			percent_armed = 1'b0;
			case (w.fmt_char)
				CH_LC_C: emit_char(w.arg_value[7:0]);
				CH_LC_D, CH_LC_I: begin
					if (low32[31])
						emit_dec(32'd0 - low32, 1'b1);
					else
						emit_dec(low32, 1'b0);
				end
				CH_LC_U: emit_dec(low32, 1'b0);
				CH_LC_X: emit_hex({32'd0, low32}, 1'b0);
				CH_UC_X: emit_hex({32'd0, low32}, 1'b1);
				CH_LC_P: begin
					emit_char(CH_ZERO);
					emit_char(CH_LC_X);
					emit_hex(w.arg_value & ptr_mask, 1'b0);
				end
				CH_PERCENT: emit_char(CH_PERCENT);
				default: ;
			endcase
		end else if (w.fmt_char == CH_PERCENT) begin
			percent_armed = 1'b1;
		end else begin
			emit_char(w.fmt_char);
		end
		if (expected_chars.size() > first) begin
			tail = expected_chars.pop_back();
			tail.last_of_run = 1'b1;
			expected_chars.push_back(tail);
		end
	endfunction

	// driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			percent_armed = 1'b0;
			chars_so_far = '0;
		end else begin
			if (item_valid && !item_stall) begin
				predict_format_byte(item);
				words_taken++;
			end
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected char %h count %0d",
						result.out_char, result.total_count));
				end else begin
					result_t want;
					want = expected_chars.pop_front();
					chars_checked++;
					if (result.out_char !== want.out_char)
						report_mismatch($sformatf("out_char %h, want %h",
							result.out_char, want.out_char));
					if (result.last_of_run !== want.last_of_run)
						report_mismatch($sformatf("last_of_run %b, want %b on char %h",
							result.last_of_run, want.last_of_run, want.out_char));
					if (result.total_count !== want.total_count)
						report_mismatch($sformatf("total_count %0d, want %0d",
							result.total_count, want.total_count));
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// stimulus

	task automatic push_item(input logic sof, input logic [7:0] ch, input logic [63:0] arg);
		pending_items.push_back('{start_of_format: sof, fmt_char: ch, arg_value: arg});
	endtask

	function automatic logic [63:0] random_arg();
		case ($urandom_range(4))
			0: return {$urandom, $urandom};
			1: return {$urandom, 32'($urandom_range(20))};
			2: return {$urandom, 32'h8000_0000 + 32'($urandom_range(8)) - 32'd4};
			3: return {$urandom, $urandom >> $urandom_range(31)};
			default: return $urandom_range(1) ? {64{1'b1}} : 64'd0;
		endcase
	endfunction

	function automatic logic [7:0] random_conversion();
		case ($urandom_range(7))
			0: return CH_LC_C;
			1: return CH_LC_D;
			2: return CH_LC_I;
			3: return CH_LC_U;
			4: return CH_LC_X;
			5: return CH_UC_X;
			6: return CH_LC_P;
			default: return CH_PERCENT;
		endcase
	endfunction

	task automatic push_directed();
		push_item(1'b1, CH_UC_A, {$urandom, $urandom});
		push_item(1'b0, 8'h00, 64'd0);
		push_item(1'b0, 8'hFF, {64{1'b1}});
		push_item(1'b0, CH_PERCENT, 64'd0);
		push_item(1'b0, CH_LC_C, 64'hFFFF_FFFF_FFFF_FF41);
		push_item(1'b0, CH_PERCENT, 64'd0);
		push_item(1'b0, CH_LC_D, 64'h1234_5678_8000_0000);
		push_item(1'b0, CH_PERCENT, 64'd0);
		push_item(1'b0, CH_LC_I, 64'h0000_0000_FFFF_FFFF);
		push_item(1'b0, CH_PERCENT, 64'd0);
		push_item(1'b0, CH_LC_D, 64'hFFFF_FFFF_7FFF_FFFF);
		push_item(1'b0, CH_PERCENT, 64'd0);
		push_item(1'b0, CH_LC_U, 64'h0000_0000_FFFF_FFFF);
		push_item(1'b0, CH_PERCENT, {64{1'b1}});
		push_item(1'b0, CH_LC_X, 64'hFFFF_FFFF_0000_0000);
		push_item(1'b0, CH_PERCENT, 64'd0);
		push_item(1'b0, CH_UC_X, 64'h0000_0000_DEAD_BEEF);
		push_item(1'b0, CH_PERCENT, 64'd0);
		push_item(1'b0, CH_LC_P, {64{1'b1}});
		push_item(1'b0, CH_PERCENT, 64'd0);
		push_item(1'b0, CH_LC_P, 64'd0);
		push_item(1'b0, CH_PERCENT, 64'd0);
		push_item(1'b0, CH_PERCENT, 64'd0);
		push_item(1'b0, CH_PERCENT, 64'd0);
		push_item(1'b0, CH_LC_S, 64'h41);
		// armed percent dropped by a new format
		push_item(1'b0, CH_PERCENT, 64'd0);
		push_item(1'b1, CH_LC_D, 64'd7);
	endtask

	task automatic push_random(input int n_words);
		int pushed;
		pushed = 0;
		while (pushed < n_words) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					push_item(1'b0, CH_PERCENT, {$urandom, $urandom});
					push_item(1'b0, random_conversion(), random_arg());
					pushed += 2;
				end
				4, 5: begin
					push_item(1'b0, 8'($urandom_range(255)), {$urandom, $urandom});
					pushed++;
				end
				6: begin
					push_item(1'b0, CH_PERCENT, {$urandom, $urandom});
					push_item(1'b0, $urandom_range(1) ? CH_LC_S : 8'($urandom_range(255)),
						random_arg());
					pushed += 2;
				end
				7: begin
					if ($urandom_range(1))
						push_item(1'b0, CH_PERCENT, random_arg());
					push_item(1'b1, $urandom_range(1) ? CH_UC_Z : random_conversion(),
						random_arg());
					pushed++;
				end
				default: begin
					push_item(1'($urandom_range(1)), 8'($urandom_range(255)),
						{$urandom, $urandom});
					pushed++;
				end
			endcase
		end
	endtask

	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		words_taken = 0;
		chars_checked = 0;
		errors = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int phase = 0; phase < 3; phase++) begin
			@(posedge clk);
			send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 56 : 0;
			recv_stall_pct = (phase == 0) ? 56 : (phase == 1) ? 29 : 0;
			if (phase == 0)
				push_directed();
			push_random(60);
			while (pending_items.size() != 0 || item_valid)
				@(posedge clk);
		end
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (expected_chars.size() != 0)
			report_mismatch($sformatf("%0d chars never came out", expected_chars.size()));
		$display("%0d format words taken, %0d chars checked over three pacing mixes",
			words_taken, chars_checked);
		$display("%0d mismatches", errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/fdp_pkg.sv
hw/rtl/fdp_front.sv
hw/rtl/fdp_queue.sv
hw/rtl/fdp_back.sv
hw/rtl/format_directed_number_printer_top.sv
tb/tb.sv
